@@ rtl/core/tlik_pkg.sv @@
`default_nettype none
package tlik_pkg;

  // Formats
  localparam int FRAC_BITS     = 16;
  localparam int ANG_BITS      = 30;
  localparam int RND_SH        = ANG_BITS - FRAC_BITS;
  localparam int COORD_W       = 20;
  localparam int LEN_W         = 18;
  localparam int OUT_W         = 20;
  localparam int NLANE         = 2;

  // CORDIC
  localparam int CORDIC_STAGES = 18;
  localparam int TABLE_LEN     = 28;
  localparam int CORD_ITERS    = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int CIN_W         = 32;
  localparam int CW            = 34;
  localparam int SHAMT_W       = 5;
  localparam int RSH_W         = 4;
  localparam int LP_W          = 6;
  localparam int NORM_MSB      = 29;

  // Datapath widths
  localparam int SQ_W          = 2 * COORD_W - 1;
  localparam int LSQ_W         = 2 * LEN_W;
  localparam int R2_W          = SQ_W + 1;
  localparam int R_W           = R2_W / 2;
  localparam int NUM_W         = R2_W + 1;
  localparam int DEN_W         = NUM_W - 2;
  localparam int S_W           = NORM_MSB + 1;
  localparam int PROD_W        = 2 * S_W;
  localparam int R_ITERS       = R_W;
  localparam int S_ITERS       = S_W;

  // Schedule (cycles)
  localparam int CORD_LAT      = CORD_ITERS + 6;
  localparam int T_AB          = 10 + R_ITERS + S_ITERS + CORD_LAT;
  localparam int GAMMA_DLY     = T_AB - 1 - CORD_LAT;
  localparam int BAD_DLY       = T_AB - 5 - R_ITERS;
  localparam int VLD_LEN       = T_AB + 1;

  // Config registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER = 1'd1;
  localparam logic [LEN_W-1:0] UPPER_RST = 18'd16379;
  localparam logic [LEN_W-1:0] LOWER_RST = 18'd17891;

  // Angles, Q.30 radians
  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW:0]   RND_HALF    = (CW+1)'(2 ** (RND_SH - 1));
  localparam logic signed [CW:0]   OUT_MAX     = (CW+1)'(2 ** (OUT_W - 1) - 1);
  localparam logic signed [CW:0]   OUT_MIN     = -(CW+1)'(2 ** (OUT_W - 1));

  // atan(2^-i), Q.30
  localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007
  };

  // Position of the leading one (0 for zero)
  function automatic logic [LP_W-1:0] lead_pos(input logic [DEN_W-1:0] v);
    logic [LP_W-1:0] p;
    p = '0;
    for (int i = 0; i < DEN_W; i++) begin
      if (v[i]) begin
        p = LP_W'(i);
      end
    end
    return p;
  endfunction

  // Q.30 -> output format, round half up, saturate
  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [CW:0] a);
    logic signed [CW:0] v;
    v = (a + RND_HALF) >>> RND_SH;
    if (v > OUT_MAX) begin
      return OUT_MAX[OUT_W-1:0];
    end else if (v < OUT_MIN) begin
      return OUT_MIN[OUT_W-1:0];
    end
    return v[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/tlik_cordic.sv @@
`default_nettype none
// Pipelined CORDIC vectoring: z = atan2(y, x) in Q.30, atan2(0,0) = 0.
module tlik_cordic (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [tlik_pkg::CIN_W-1:0] x_i,
  input  logic signed [tlik_pkg::CIN_W-1:0] y_i,
  output logic signed [tlik_pkg::CW-1:0]    z_o
);
  import tlik_pkg::*;

  logic signed [CIN_W-1:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q;
  logic [CIN_W-1:0]        m1_q, ax, ay;
  logic                    zr1_q, zr2_q, zr3_q;
  logic [SHAMT_W-1:0]      sh2_q, sh_d;
  logic [LP_W-1:0]         lp;
  logic signed [CW-1:0]    x3_q, y3_q, x2e, y2e;
  logic signed [CW-1:0]    x4_d, y4_d, z4_d;
  logic signed [CW-1:0]    xs_q [CORD_ITERS+1];
  logic signed [CW-1:0]    ys_q [CORD_ITERS+1];
  logic signed [CW-1:0]    zs_q [CORD_ITERS+1];
  logic                    zf_q [CORD_ITERS+1];
  logic signed [CW-1:0]    xn [CORD_ITERS];
  logic signed [CW-1:0]    yn [CORD_ITERS];
  logic signed [CW-1:0]    zn [CORD_ITERS];
  logic signed [CW-1:0]    z_q;

  always_comb begin
    ax  = x0_q[CIN_W-1] ? $unsigned(-x0_q) : $unsigned(x0_q);
    ay  = y0_q[CIN_W-1] ? $unsigned(-y0_q) : $unsigned(y0_q);
    lp  = lead_pos(DEN_W'(m1_q));
    sh_d = (lp < LP_W'(NORM_MSB)) ? SHAMT_W'(LP_W'(NORM_MSB) - lp) : '0;
    x2e = {{(CW-CIN_W){x2_q[CIN_W-1]}}, x2_q};
    y2e = {{(CW-CIN_W){y2_q[CIN_W-1]}}, y2_q};
  end

  // fold left half plane onto the right
  always_comb begin
    x4_d = x3_q;
    y4_d = y3_q;
    z4_d = '0;
    if (x3_q < 0) begin
      if (y3_q >= 0) begin
        x4_d = y3_q;
        y4_d = -x3_q;
        z4_d = HALF_PI_Q30;
      end else begin
        x4_d = -y3_q;
        y4_d = x3_q;
        z4_d = -HALF_PI_Q30;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CORD_ITERS; i++) begin
      if (ys_q[i] > 0) begin
        xn[i] = xs_q[i] + (ys_q[i] >>> i);
        yn[i] = ys_q[i] - (xs_q[i] >>> i);
        zn[i] = zs_q[i] + $signed(CW'(ATAN_TAB[i]));
      end else begin
        xn[i] = xs_q[i] - (ys_q[i] >>> i);
        yn[i] = ys_q[i] + (xs_q[i] >>> i);
        zn[i] = zs_q[i] - $signed(CW'(ATAN_TAB[i]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q  <= x_i;
      y0_q  <= y_i;
      m1_q  <= ax | ay;
      x1_q  <= x0_q;
      y1_q  <= y0_q;
      zr1_q <= (x0_q == '0) && (y0_q == '0);
      sh2_q <= sh_d;
      x2_q  <= x1_q;
      y2_q  <= y1_q;
      zr2_q <= zr1_q;
      x3_q  <= x2e <<< sh2_q;
      y3_q  <= y2e <<< sh2_q;
      zr3_q <= zr2_q;
      xs_q[0] <= x4_d;
      ys_q[0] <= y4_d;
      zs_q[0] <= z4_d;
      zf_q[0] <= zr3_q;
      for (int i = 0; i < CORD_ITERS; i++) begin
        xs_q[i+1] <= xn[i];
        ys_q[i+1] <= yn[i];
        zs_q[i+1] <= zn[i];
        zf_q[i+1] <= zf_q[i];
      end
      z_q <= zf_q[CORD_ITERS] ? '0 : zs_q[CORD_ITERS];
    end
  end

  assign z_o = z_q;

endmodule
`default_nettype wire

@@ rtl/core/two_link_inverse_kinematics_core.sv @@
`default_nettype none
// Two-link planar arm inverse kinematics.
// Input channel (in_valid_i / in_stall_o): one target (x, y), signed Q3.16 m.
// Output channel (out_valid_o / out_stall_i): shoulder and elbow angles,
//   signed Q3.16 rad, plus an unreachable flag (acos argument clamped or
//   target at origin / zero link).
// Link lengths are set through the write port (index 0 upper, 1 lower);
// write them only while no item is in flight.
// Throughput: one item per cycle while in_stall_o is low. The delay from the
//   accepting edge to out_valid_o is set by the r = sqrt(x^2+y^2) digit
//   pipeline (20 stages), the sqrt(d^2-n^2) digit pipeline (30 stages) and
//   the CORDIC pipeline.
// Stall: a valid output register holds while out_stall_i is high; the rest of
//   the pipeline keeps moving while the last stage is empty, so bubbles are
//   squeezed out and an item is still taken while a result waits.
// Reset: clears all valid bits and loads the default link lengths.
module two_link_inverse_kinematics_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [tlik_pkg::COORD_W-1:0]  target_x_i,
  input  logic signed [tlik_pkg::COORD_W-1:0]  target_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [tlik_pkg::OUT_W-1:0]    shoulder_angle_o,
  output logic signed [tlik_pkg::OUT_W-1:0]    elbow_angle_o,
  output logic                                 unreachable_o,
  input  logic                                 cfg_we_i,
  input  logic [tlik_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tlik_pkg::LEN_W-1:0]           cfg_wdata_i
);
  import tlik_pkg::*;

  localparam int RT_W = R2_W + 2;
  localparam int ST_W = PROD_W + 2;

  // ---- config and derived constants -------------------------------------
  logic [LEN_W-1:0]        up_len_q, lo_len_q;
  logic [LSQ_W-1:0]        l1sq_q, l2sq_q, l1l2_q;
  logic [LSQ_W:0]          sumsq_q;
  logic signed [LSQ_W:0]   diffsq_q;
  logic [DEN_W-1:0]        den2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_len_q <= UPPER_RST;
      lo_len_q <= LOWER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_UPPER: up_len_q <= cfg_wdata_i;
        REG_LOWER: lo_len_q <= cfg_wdata_i;
      endcase
    end
  end

  // free running: products, then sums and difference, each registered; settles long before use
  always_ff @(posedge clk_i) begin
    l1sq_q   <= LSQ_W'(up_len_q) * LSQ_W'(up_len_q);
    l2sq_q   <= LSQ_W'(lo_len_q) * LSQ_W'(lo_len_q);
    l1l2_q   <= LSQ_W'(up_len_q) * LSQ_W'(lo_len_q);
    sumsq_q  <= (LSQ_W+1)'(l1sq_q) + (LSQ_W+1)'(l2sq_q);
    diffsq_q <= $signed({1'b0, l1sq_q}) - $signed({1'b0, l2sq_q});
    den2_q   <= DEN_W'({l1l2_q, 1'b0});
  end

  // ---- flow control -------------------------------------------------------
  logic               oen, pen;
  logic [VLD_LEN-1:0] vld_q;
  logic               out_vld_q;

  assign oen        = !out_vld_q || !out_stall_i;
  assign pen        = oen || !vld_q[VLD_LEN-1];
  assign in_stall_o = !pen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (pen) begin
        vld_q <= {vld_q[VLD_LEN-2:0], in_valid_i};
      end
      if (oen) begin
        out_vld_q <= vld_q[VLD_LEN-1];
      end
    end
  end

  // ---- squares and r^2 -----------------------------------------------------
  logic signed [COORD_W-1:0]   x0_q, y0_q;
  logic signed [2*COORD_W-1:0] xx, yy;
  logic [SQ_W-1:0]             xsq_q, ysq_q;

  assign xx = (2*COORD_W)'(x0_q) * (2*COORD_W)'(x0_q);
  assign yy = (2*COORD_W)'(y0_q) * (2*COORD_W)'(y0_q);

  // ---- r = isqrt(r^2), one result bit per stage ---------------------------
  logic [R2_W-1:0] rr_rem_q  [R_ITERS+1];
  logic [R_W-1:0]  rr_root_q [R_ITERS+1];
  logic [R2_W-1:0] rr_r2_q   [R_ITERS+1];
  logic [RT_W-1:0] rr_try    [R_ITERS];
  logic [R2_W-1:0] rr_rem_d  [R_ITERS];
  logic [R_W-1:0]  rr_root_d [R_ITERS];

  always_comb begin
    for (int k = 0; k < R_ITERS; k++) begin
      rr_try[k] = (RT_W'(rr_root_q[k]) << (R_ITERS - k))
                + (RT_W'(1) << (2 * (R_ITERS - 1 - k)));
      if ({2'b00, rr_rem_q[k]} >= rr_try[k]) begin
        rr_rem_d[k]  = rr_rem_q[k] - rr_try[k][R2_W-1:0];
        rr_root_d[k] = rr_root_q[k] | (R_W'(1) << (R_ITERS - 1 - k));
      end else begin
        rr_rem_d[k]  = rr_rem_q[k];
        rr_root_d[k] = rr_root_q[k];
      end
    end
  end

  // ---- acos lanes: 0 = alpha (shoulder), 1 = beta (elbow) ------------------
  logic [LEN_W+R_W-1:0]    lr;
  logic signed [NUM_W-1:0] an_q  [NLANE];
  logic [DEN_W-1:0]        ad_q  [NLANE];
  logic signed [NUM_W-1:0] dsg   [NLANE];
  logic signed [NUM_W-1:0] cn_d  [NLANE];
  logic [DEN_W-1:0]        cd_d  [NLANE];
  logic                    cb_d  [NLANE];
  logic signed [NUM_W-1:0] cn_q  [NLANE];
  logic [DEN_W-1:0]        cd_q  [NLANE];
  logic                    ac_bad_q [NLANE];
  logic signed [NUM_W-1:0] nn_q  [NLANE];
  logic [DEN_W-1:0]        nd_q  [NLANE];
  logic [LP_W-1:0]         lp    [NLANE];
  logic [RSH_W-1:0]        shr_q [NLANE];
  logic [SHAMT_W-1:0]      shl_q [NLANE];
  logic signed [NUM_W-1:0] sn    [NLANE];
  logic [DEN_W-1:0]        sd    [NLANE];
  logic signed [CIN_W-1:0] hn_q  [NLANE];
  logic [S_W-1:0]          hd_q  [NLANE];
  logic signed [CIN_W-1:0] hsg   [NLANE];
  logic signed [CIN_W-1:0] kn_d  [NLANE];
  logic signed [CIN_W-1:0] kn_q  [NLANE];
  logic [S_W-1:0]          kd_q  [NLANE];
  logic signed [CIN_W-1:0] ksg   [NLANE];
  logic [CIN_W-1:0]        dm_q  [NLANE];
  logic [CIN_W-1:0]        dp_q  [NLANE];
  logic signed [CIN_W-1:0] mn_q  [NLANE];
  logic [2*CIN_W-1:0]      pr    [NLANE];

  assign lr = (LEN_W+R_W)'(up_len_q) * (LEN_W+R_W)'(rr_root_q[R_ITERS]);

  // clamp to [-den, den]; zero denominator gives sign of numerator
  always_comb begin
    for (int j = 0; j < NLANE; j++) begin
      dsg[j]  = $signed({2'b00, ad_q[j]});
      cn_d[j] = an_q[j];
      cd_d[j] = ad_q[j];
      cb_d[j] = 1'b0;
      if (ad_q[j] == '0) begin
        cb_d[j] = 1'b1;
        cd_d[j] = DEN_W'(1);
        if (an_q[j] > 0) begin
          cn_d[j] = NUM_W'(1);
        end else if (an_q[j] < 0) begin
          cn_d[j] = '1;
        end else begin
          cn_d[j] = '0;
        end
      end else if (an_q[j] > dsg[j]) begin
        cb_d[j] = 1'b1;
        cn_d[j] = dsg[j];
      end else if (an_q[j] < -dsg[j]) begin
        cb_d[j] = 1'b1;
        cn_d[j] = -dsg[j];
      end
      lp[j]  = lead_pos(cd_q[j]);
      sd[j]  = (nd_q[j] >> shr_q[j]) << shl_q[j];
      sn[j]  = (nn_q[j] >>> shr_q[j]) <<< shl_q[j];
      hsg[j] = $signed({2'b00, hd_q[j]});
      kn_d[j] = hn_q[j];
      if (hn_q[j] > hsg[j]) begin
        kn_d[j] = hsg[j];
      end else if (hn_q[j] < -hsg[j]) begin
        kn_d[j] = -hsg[j];
      end
      ksg[j] = $signed({2'b00, kd_q[j]});
      pr[j]  = (2*CIN_W)'(dm_q[j]) * (2*CIN_W)'(dp_q[j]);
    end
  end

  // ---- s = isqrt(den^2 - num^2) per lane ----------------------------------
  logic [PROD_W-1:0]       ss_rem_q  [NLANE][S_ITERS+1];
  logic [S_W-1:0]          ss_root_q [NLANE][S_ITERS+1];
  logic signed [CIN_W-1:0] ss_num_q  [NLANE][S_ITERS+1];
  logic [ST_W-1:0]         ss_try    [NLANE][S_ITERS];
  logic [PROD_W-1:0]       ss_rem_d  [NLANE][S_ITERS];
  logic [S_W-1:0]          ss_root_d [NLANE][S_ITERS];

  always_comb begin
    for (int j = 0; j < NLANE; j++) begin
      for (int k = 0; k < S_ITERS; k++) begin
        ss_try[j][k] = (ST_W'(ss_root_q[j][k]) << (S_ITERS - k))
                     + (ST_W'(1) << (2 * (S_ITERS - 1 - k)));
        if ({2'b00, ss_rem_q[j][k]} >= ss_try[j][k]) begin
          ss_rem_d[j][k]  = ss_rem_q[j][k] - ss_try[j][k][PROD_W-1:0];
          ss_root_d[j][k] = ss_root_q[j][k] | (S_W'(1) << (S_ITERS - 1 - k));
        end else begin
          ss_rem_d[j][k]  = ss_rem_q[j][k];
          ss_root_d[j][k] = ss_root_q[j][k];
        end
      end
    end
  end

  // ---- main pipeline registers --------------------------------------------
  logic [BAD_DLY-1:0] bd_q;

  always_ff @(posedge clk_i) begin
    if (pen) begin
      x0_q  <= target_x_i;
      y0_q  <= target_y_i;
      xsq_q <= xx[SQ_W-1:0];
      ysq_q <= yy[SQ_W-1:0];
      rr_rem_q[0]  <= R2_W'(xsq_q) + R2_W'(ysq_q);
      rr_r2_q[0]   <= R2_W'(xsq_q) + R2_W'(ysq_q);
      rr_root_q[0] <= '0;
      for (int k = 0; k < R_ITERS; k++) begin
        rr_rem_q[k+1]  <= rr_rem_d[k];
        rr_root_q[k+1] <= rr_root_d[k];
        rr_r2_q[k+1]   <= rr_r2_q[k];
      end
      an_q[0] <= $signed({1'b0, rr_r2_q[R_ITERS]}) + NUM_W'(diffsq_q);
      ad_q[0] <= DEN_W'({lr, 1'b0});
      an_q[1] <= $signed(NUM_W'(sumsq_q)) - $signed({1'b0, rr_r2_q[R_ITERS]});
      ad_q[1] <= den2_q;
      for (int j = 0; j < NLANE; j++) begin
        cn_q[j]     <= cn_d[j];
        cd_q[j]     <= cd_d[j];
        ac_bad_q[j] <= cb_d[j];
        nn_q[j]     <= cn_q[j];
        nd_q[j]     <= cd_q[j];
        shr_q[j]    <= (lp[j] > LP_W'(NORM_MSB)) ? RSH_W'(lp[j] - LP_W'(NORM_MSB)) : '0;
        shl_q[j]    <= (lp[j] < LP_W'(NORM_MSB)) ? SHAMT_W'(LP_W'(NORM_MSB) - lp[j]) : '0;
        hn_q[j]     <= sn[j][CIN_W-1:0];
        hd_q[j]     <= sd[j][S_W-1:0];
        kn_q[j]     <= kn_d[j];
        kd_q[j]     <= hd_q[j];
        dm_q[j]     <= $unsigned(ksg[j] - kn_q[j]);
        dp_q[j]     <= $unsigned(ksg[j] + kn_q[j]);
        mn_q[j]     <= kn_q[j];
        ss_rem_q[j][0]  <= pr[j][PROD_W-1:0];
        ss_root_q[j][0] <= '0;
        ss_num_q[j][0]  <= mn_q[j];
        for (int k = 0; k < S_ITERS; k++) begin
          ss_rem_q[j][k+1]  <= ss_rem_d[j][k];
          ss_root_q[j][k+1] <= ss_root_d[j][k];
          ss_num_q[j][k+1]  <= ss_num_q[j][k];
        end
      end
      bd_q <= {bd_q[BAD_DLY-2:0], ac_bad_q[0] | ac_bad_q[1]};
    end
  end

  // ---- CORDIC units ---------------------------------------------------------
  logic signed [CW-1:0] gamma_z;
  logic signed [CW-1:0] ang_z [NLANE];
  logic signed [CW-1:0] gd_q  [GAMMA_DLY];

  tlik_cordic u_gamma (
    .clk_i (clk_i),
    .en_i  (pen),
    .x_i   (CIN_W'(x0_q)),
    .y_i   (CIN_W'(y0_q)),
    .z_o   (gamma_z)
  );

  for (genvar j = 0; j < NLANE; j++) begin : g_acos
    tlik_cordic u_acos (
      .clk_i (clk_i),
      .en_i  (pen),
      .x_i   (ss_num_q[j][S_ITERS]),
      .y_i   ($signed(CIN_W'(ss_root_q[j][S_ITERS]))),
      .z_o   (ang_z[j])
    );
  end

  // ---- angle assembly and output register ---------------------------------
  logic signed [CW:0] sh_q, el_q;
  logic               bad_q;
  logic signed [OUT_W-1:0] sh_out_q, el_out_q;
  logic               unr_q;

  always_ff @(posedge clk_i) begin
    if (pen) begin
      gd_q[0] <= gamma_z;
      for (int k = 1; k < GAMMA_DLY; k++) begin
        gd_q[k] <= gd_q[k-1];
      end
      sh_q  <= (CW+1)'(gd_q[GAMMA_DLY-1]) - (CW+1)'(ang_z[0]);
      el_q  <= (CW+1)'(PI_Q30) - (CW+1)'(ang_z[1]);
      bad_q <= bd_q[BAD_DLY-1];
    end
    if (oen) begin
      sh_out_q <= to_out(sh_q);
      el_out_q <= to_out(el_q);
      unr_q    <= bad_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign shoulder_angle_o = sh_out_q;
  assign elbow_angle_o    = el_out_q;
  assign unreachable_o    = unr_q;

endmodule
`default_nettype wire
